### rtl/core/binary_classification_metrics_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binary classification metrics block
// Shorthand for the clocked concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef BINARY_CLASSIFICATION_METRICS_MACROS_SVH
`define BINARY_CLASSIFICATION_METRICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BCM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the following cycle");

`endif

### rtl/core/bcm_pkg.sv
// ---------------------------------------------------------------------------
// bcm_pkg
// Shared widths, types and constants of the classification metrics block.
// ---------------------------------------------------------------------------
package bcm_pkg;

    localparam int COUNT_BITS = 20;
    localparam int OUT_CNT_W  = 20;
    localparam int LABEL_W    = 2;
    localparam int SCORE_W    = 16;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_W    = FRAC_BITS + 1;
    // A denominator sums up to four counts.
    localparam int DEN_W      = COUNT_BITS + 2;

    localparam logic [LABEL_W-1:0] LABEL_NEG = LABEL_W'(0);
    localparam logic [LABEL_W-1:0] LABEL_POS = LABEL_W'(1);

    localparam logic signed [SCORE_W-1:0] THRESH_RESET = SCORE_W'(2048);

    typedef logic [COUNT_BITS-1:0]     cnt_t;
    typedef logic [OUT_CNT_W-1:0]      cnt_field_t;
    typedef logic [DEN_W-1:0]          den_t;
    typedef logic [RATIO_W-1:0]        ratio_t;
    typedef logic [LABEL_W-1:0]        label_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        cnt_t tp;
        cnt_t fp;
        cnt_t tn;
        cnt_t fn;
        logic err;
    } counts_t;

    // Fits a counter into the fixed output field width.
    function automatic cnt_field_t to_field(input cnt_t c);
        logic [COUNT_BITS+OUT_CNT_W-1:0] w;
        begin
            w = {{OUT_CNT_W{1'b0}}, c};
            return w[OUT_CNT_W-1:0];
        end
    endfunction

endpackage

### rtl/core/binary_classification_metrics.sv
// ---------------------------------------------------------------------------
// binary_classification_metrics
// Confusion matrix counts and Q1.16 accuracy, precision, recall and F1.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  --------------------------------------
//   in       in_valid / in_stall       true_label, score, last
//   out      out_valid / out_stall     status, four counts, four ratios
//   cfg      cfg_wr_en                 cfg_wr_data (threshold)
//
// An input transaction without last is taken at once, and the next one can
// follow in the next cycle. A transaction with last starts the ratio phase:
// one shared restoring divider computes the four ratios in turn, so the block
// holds in_stall high until the result is loaded into the output register.
// The result then waits in the output register while new input is taken.
// Reset clears the counters, the error flag and the output valid, and sets
// the threshold to 0.5. A stalled output only delays loading the next
// result.
// ---------------------------------------------------------------------------
`include "binary_classification_metrics_macros.svh"

module binary_classification_metrics (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  bcm_pkg::score_t     cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  bcm_pkg::label_t     true_label,
    input  bcm_pkg::score_t     score,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output bcm_pkg::cnt_field_t true_pos,
    output bcm_pkg::cnt_field_t false_pos,
    output bcm_pkg::cnt_field_t true_neg,
    output bcm_pkg::cnt_field_t false_neg,
    output bcm_pkg::ratio_t     accuracy,
    output bcm_pkg::ratio_t     precision,
    output bcm_pkg::ratio_t     recall,
    output bcm_pkg::ratio_t     f1_score
);
    import bcm_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    // Ratio order through the divider.
    localparam logic [1:0] R_ACC  = 2'd0;
    localparam logic [1:0] R_PREC = 2'd1;
    localparam logic [1:0] R_REC  = 2'd2;
    localparam logic [1:0] R_F1   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    score_t     thresh_reg;
    ratio_t     ratio_reg [4];

    counts_t counts;
    logic    in_accept;
    logic    out_free;
    logic    load;
    logic    div_start;
    logic    div_done;
    ratio_t  div_q;
    den_t    num_mux;
    den_t    den_mux;
    den_t    tp_w;
    den_t    fp_w;
    den_t    tn_w;
    den_t    fn_w;

    logic       out_valid_reg;
    logic       status_reg;
    cnt_field_t tp_out_reg;
    cnt_field_t fp_out_reg;
    cnt_field_t tn_out_reg;
    cnt_field_t fn_out_reg;
    ratio_t     acc_out_reg;
    ratio_t     prec_out_reg;
    ratio_t     rec_out_reg;
    ratio_t     f1_out_reg;

    // Input is taken only while no batch is being finished.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = (state_reg == ST_LOAD) && out_free;
    assign div_start = (state_reg == ST_START);

    // Threshold register; the user must write it only while the block is idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    bcm_counters u_counters (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .label     (true_label),
        .score     (score),
        .threshold (thresh_reg),
        .clear     (load),
        .counts    (counts)
    );

    // Counts widened to denominator width before any sum.
    assign tp_w = DEN_W'(counts.tp);
    assign fp_w = DEN_W'(counts.fp);
    assign tn_w = DEN_W'(counts.tn);
    assign fn_w = DEN_W'(counts.fn);

    // Operand selection for the ratio currently in the divider.
    always_comb
    begin
        unique case (idx_reg)
            R_ACC:
            begin
                num_mux = tp_w + tn_w;
                den_mux = tp_w + fp_w + tn_w + fn_w;
            end
            R_PREC:
            begin
                num_mux = tp_w;
                den_mux = tp_w + fp_w;
            end
            R_REC:
            begin
                num_mux = tp_w;
                den_mux = tp_w + fn_w;
            end
            R_F1:
            begin
                num_mux = {tp_w[DEN_W-2:0], 1'b0};
                den_mux = {tp_w[DEN_W-2:0], 1'b0} + fp_w + fn_w;
            end
            default:
            begin
                num_mux = '0;
                den_mux = '0;
            end
        endcase
    end

    bcm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_mux),
        .den      (den_mux),
        .done     (div_done),
        .quotient (div_q)
    );

    // The counters hold the batch snapshot until the result is loaded.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last)
                begin
                    state_next = ST_START;
                    idx_next   = R_ACC;
                end
            end
            ST_START:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (div_done)
                begin
                    if (idx_reg == R_F1)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_START;
                        idx_next   = idx_reg + 2'd1;
                    end
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= R_ACC;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RUN) && div_done)
        begin
            ratio_reg[idx_reg] <= div_q;
        end
    end

    // Output register: a waiting result does not block new input.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg   <= counts.err;
            tp_out_reg   <= to_field(counts.tp);
            fp_out_reg   <= to_field(counts.fp);
            tn_out_reg   <= to_field(counts.tn);
            fn_out_reg   <= to_field(counts.fn);
            acc_out_reg  <= ratio_reg[R_ACC];
            prec_out_reg <= ratio_reg[R_PREC];
            rec_out_reg  <= ratio_reg[R_REC];
            f1_out_reg   <= ratio_reg[R_F1];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign true_pos  = tp_out_reg;
    assign false_pos = fp_out_reg;
    assign true_neg  = tn_out_reg;
    assign false_neg = fn_out_reg;
    assign accuracy  = acc_out_reg;
    assign precision = prec_out_reg;
    assign recall    = rec_out_reg;
    assign f1_score  = f1_out_reg;

    // A transaction that ends a batch must close the input right away.
    `BCM_ASSERT_NEXT(a_last_closes_input, in_valid && !in_stall && last, in_stall)
    // The divider finishes only while the sequencer waits for it.
    `BCM_ASSERT_NOW(a_done_in_run, div_done, state_reg == ST_RUN)
    // A result never overwrites one that is still stalled.
    `BCM_ASSERT_NOW(a_load_free, load, !(out_valid_reg && out_stall))
    // Loading a result starts a fresh batch.
    `BCM_ASSERT_NEXT(a_clear_after_load, load,
                     counts.tp == '0 && counts.fp == '0 && counts.tn == '0 &&
                     counts.fn == '0 && !counts.err && out_valid)

endmodule

### rtl/core/bcm_counters.sv
// ---------------------------------------------------------------------------
// bcm_counters
// Threshold compare and the four saturating outcome counters.
// ---------------------------------------------------------------------------
module bcm_counters (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  bcm_pkg::label_t  label,
    input  bcm_pkg::score_t  score,
    input  bcm_pkg::score_t  threshold,
    input  logic             clear,
    output bcm_pkg::counts_t counts
);
    import bcm_pkg::*;

    counts_t cnt_reg;
    counts_t cnt_next;
    logic    pred_pos;

    assign pred_pos = (score >= threshold);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (accept)
        begin
            unique case (label)
                LABEL_NEG:
                begin
                    if (pred_pos)
                    begin
                        if (cnt_reg.fp != '1) cnt_next.fp = cnt_reg.fp + cnt_t'(1);
                    end
                    else
                    begin
                        if (cnt_reg.tn != '1) cnt_next.tn = cnt_reg.tn + cnt_t'(1);
                    end
                end
                LABEL_POS:
                begin
                    if (pred_pos)
                    begin
                        if (cnt_reg.tp != '1) cnt_next.tp = cnt_reg.tp + cnt_t'(1);
                    end
                    else
                    begin
                        if (cnt_reg.fn != '1) cnt_next.fn = cnt_reg.fn + cnt_t'(1);
                    end
                end
                default:
                begin
                    cnt_next.err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign counts = cnt_reg;

endmodule

### rtl/core/bcm_divider.sv
// ---------------------------------------------------------------------------
// bcm_divider
// Restoring divider giving one Q1.16 quotient bit per cycle (num <= den).
// ---------------------------------------------------------------------------
module bcm_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  bcm_pkg::den_t   num,
    input  bcm_pkg::den_t   den,
    output logic            done,
    output bcm_pkg::ratio_t quotient
);
    import bcm_pkg::*;

    localparam int STEP_W = $clog2(RATIO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATIO_W - 1);

    logic [DEN_W:0]    rem_reg;
    logic [DEN_W:0]    rem_next;
    den_t              den_reg;
    ratio_t            q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic [DEN_W:0]    diff;

    // Remainder stays below twice den, so one compare and subtract per bit.
    assign ge       = (rem_reg >= {1'b0, den_reg});
    assign diff     = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign rem_next = {diff[DEN_W-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[RATIO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    // A zero denominator gives a ratio of zero.
    assign quotient = (den_reg == '0) ? '0 : q_reg;

endmodule

### tb/sv/tb_binary_classification_metrics.sv
// ----------------------------------------------------------------------------
// Testbench for binary_classification_metrics
// Streams labeled score pairs through the block in batches, predicts the
// confusion counts and Q1.16 ratios of every batch, and compares each result
// transaction field by field. Covers threshold extremes, invalid labels,
// zero denominators, and random batches under random source gaps and sink
// stalls.
// ----------------------------------------------------------------------------
module tb_binary_classification_metrics;
    import bcm_pkg::*;

    // Labels 2 and 3 are invalid classes that only raise the status flag.
    localparam label_t LABEL_INVALID_LO = 2'd2;
    localparam label_t LABEL_INVALID_HI = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PAIRS   = 225;
    // The final drain waits longer than the ratio phase takes.
    localparam int DRAIN_CYCLES  = 100;
    // Gap between the last result and a threshold write.
    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_ROWS = 23;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic       status;
        cnt_field_t tp;
        cnt_field_t fp;
        cnt_field_t tn;
        cnt_field_t fn;
        ratio_t     accuracy;
        ratio_t     precision;
        ratio_t     recall;
        ratio_t     f1;
    } report_t;

    // One row of the directed table: either a threshold write or a pair.
    // When typed is set the row carries its own expected report.
    typedef struct {
        bit      is_cfg;
        score_t  value;
        label_t  label;
        score_t  score;
        bit      last;
        bit      typed;
        report_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    score_t     cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    label_t     true_label;
    score_t     score;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic       status;
    cnt_field_t true_pos;
    cnt_field_t false_pos;
    cnt_field_t true_neg;
    cnt_field_t false_neg;
    ratio_t     accuracy;
    ratio_t     precision;
    ratio_t     recall;
    ratio_t     f1_score;

    // Predictor state: the threshold and the running confusion matrix.
    score_t  model_threshold;
    cnt_t    tp_cnt;
    cnt_t    fp_cnt;
    cnt_t    tn_cnt;
    cnt_t    fn_cnt;
    logic    bad_label_seen;

    // Batch reports that the block still owes, oldest first.
    report_t awaited_reports[$];
    report_t oldest_report;

    int      error_count;
    int      cycle_count;
    int      stall_left;
    bit      stall_drawn;
    // When set, neither side inserts gaps or stalls.
    bit      steady;

    stim_row_t directed_rows[DIRECTED_ROWS];

    binary_classification_metrics dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .true_label  (true_label),
        .score       (score),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .true_pos    (true_pos),
        .false_pos   (false_pos),
        .true_neg    (true_neg),
        .false_neg   (false_neg),
        .accuracy    (accuracy),
        .precision   (precision),
        .recall      (recall),
        .f1_score    (f1_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A counter that is already full stays full.
    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Truncated Q1.16 quotient; a zero denominator yields zero.
    function automatic ratio_t q16_fraction(input longint unsigned num,
                                            input longint unsigned den);
        if (den == 0)
            return '0;
        return ratio_t'((num << 16) / den);
    endfunction

    function automatic report_t make_report(input int st, input int tp, input int fp,
                                            input int tn, input int fn, input int acc,
                                            input int prec, input int rec, input int f1);
        report_t r;
        r.status    = st[0];
        r.tp        = cnt_field_t'(tp);
        r.fp        = cnt_field_t'(fp);
        r.tn        = cnt_field_t'(tn);
        r.fn        = cnt_field_t'(fn);
        r.accuracy  = ratio_t'(acc);
        r.precision = ratio_t'(prec);
        r.recall    = ratio_t'(rec);
        r.f1        = ratio_t'(f1);
        return r;
    endfunction

    function automatic stim_row_t pair_row(input label_t l, input score_t s, input bit lst);
        stim_row_t row;
        row = '{default: '0};
        row.label = l;
        row.score = s;
        row.last  = lst;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input label_t l, input score_t s,
                                              input report_t want);
        stim_row_t row;
        row = pair_row(l, s, 1'b1);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input score_t v);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.value  = v;
        return row;
    endfunction

    // Classifies one pair against the threshold and bumps the matching
    // counter. On the closing pair of a batch it forms the report and
    // starts a fresh batch.
    task automatic count_pair(input label_t l, input score_t s, input logic lst,
                              output bit fired, output report_t rep);
        logic            positive;
        longint unsigned tp;
        longint unsigned fp;
        longint unsigned tn;
        longint unsigned fn;
        positive = (s >= model_threshold);
        case (l)
            LABEL_NEG:
            begin
                if (positive)
                    fp_cnt = sat_inc(fp_cnt);
                else
                    tn_cnt = sat_inc(tn_cnt);
            end
            LABEL_POS:
            begin
                if (positive)
                    tp_cnt = sat_inc(tp_cnt);
                else
                    fn_cnt = sat_inc(fn_cnt);
            end
            default:
                bad_label_seen = 1'b1;
        endcase
        fired = lst;
        rep   = '0;
        if (lst)
        begin
            tp = tp_cnt;
            fp = fp_cnt;
            tn = tn_cnt;
            fn = fn_cnt;
            rep.status    = bad_label_seen;
            rep.tp        = tp_cnt;
            rep.fp        = fp_cnt;
            rep.tn        = tn_cnt;
            rep.fn        = fn_cnt;
            rep.accuracy  = q16_fraction(tp + tn, tp + fp + tn + fn);
            rep.precision = q16_fraction(tp, tp + fp);
            rep.recall    = q16_fraction(tp, tp + fn);
            rep.f1        = q16_fraction(2 * tp, 2 * tp + fp + fn);
            tp_cnt = '0;
            fp_cnt = '0;
            tn_cnt = '0;
            fn_cnt = '0;
            bad_label_seen = 1'b0;
        end
    endtask

    // Drives one input transaction and waits for the block to take it.
    // Valid is left high on return so that a back-to-back transaction
    // never lowers and raises it in the same step.
    task automatic send_pair(input label_t l, input score_t s, input bit lst,
                             input bit typed, input report_t want);
        int      gap;
        bit      fired;
        report_t rep;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        true_label <= l;
        score      <= s;
        last       <= lst;
        do
            @(posedge clk);
        while (in_stall);
        count_pair(l, s, lst, fired, rep);
        if (fired)
            awaited_reports.push_back(typed ? want : rep);
    endtask

    // Stops the source until every owed report has arrived.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input score_t v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_threshold = v;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result checker: every accepted result transaction is matched against
    // the oldest report that is still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stall_drawn = 1'b0;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: result transaction with no batch awaiting it", $time);
                error_count++;
            end
            else
            begin
                oldest_report = awaited_reports.pop_front();
                check_field("status", oldest_report.status, status);
                check_field("true_pos", oldest_report.tp, true_pos);
                check_field("false_pos", oldest_report.fp, false_pos);
                check_field("true_neg", oldest_report.tn, true_neg);
                check_field("false_neg", oldest_report.fn, false_neg);
                check_field("accuracy", oldest_report.accuracy, accuracy);
                check_field("precision", oldest_report.precision, precision);
                check_field("recall", oldest_report.recall, recall);
                check_field("f1_score", oldest_report.f1, f1_score);
            end
        end
    end

    // Sink: when a new result shows up, draw how long to hold it off.
    // Results are far apart, so the stall is drawn against the valid
    // result rather than right after the previous acceptance.
    always @(negedge clk)
    begin
        if (out_valid && !stall_drawn)
        begin
            stall_left  = steady ? 0 : $urandom_range(0, 4);
            stall_drawn = 1'b1;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("binary_classification_metrics regression: fail");
            $finish;
        end
    end

    initial
    begin
        int     phase;
        int     left;
        int     blen;
        int     i;
        int     r;
        int     v;
        label_t l;
        score_t s;
        score_t thr;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        true_label      = '0;
        score           = '0;
        last            = 1'b0;
        out_stall       = 1'b0;
        steady          = 1'b0;
        stall_left      = 0;
        stall_drawn     = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        model_threshold = THRESH_RESET;
        tp_cnt          = '0;
        fp_cnt          = '0;
        tn_cnt          = '0;
        fn_cnt          = '0;
        bad_label_seen  = 1'b0;

        // Single-pair batches at the reset threshold of 0.5: one of each
        // outcome, so the ratios are either full scale or zero, and a
        // denominator of zero gives zero.
        directed_rows[0]  = checked_row(LABEL_NEG, 16'sh8000,
                                        make_report(0, 0, 0, 1, 0, 65536, 0, 0, 0));
        directed_rows[1]  = checked_row(LABEL_POS, 16'sh7FFF,
                                        make_report(0, 1, 0, 0, 0, 65536, 65536, 65536,
                                                    65536));
        // Just below the threshold is negative, exactly at it is positive.
        directed_rows[2]  = checked_row(LABEL_POS, 16'sd2047,
                                        make_report(0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_rows[3]  = checked_row(LABEL_NEG, 16'sd2048,
                                        make_report(0, 0, 1, 0, 0, 0, 0, 0, 0));
        // A batch of one invalid label: status set, nothing counted.
        directed_rows[4]  = checked_row(LABEL_INVALID_LO, 16'sd0,
                                        make_report(1, 0, 0, 0, 0, 0, 0, 0, 0));
        // The error flag sticks through the batch; the invalid score is ignored.
        directed_rows[5]  = pair_row(LABEL_INVALID_HI, 16'sh7FFF, 1'b0);
        directed_rows[6]  = checked_row(LABEL_POS, 16'sh7FFF,
                                        make_report(1, 1, 0, 0, 0, 65536, 65536, 65536,
                                                    65536));
        // A mixed batch, checked against the predictor.
        directed_rows[7]  = pair_row(LABEL_NEG, 16'sh7FFF, 1'b0);
        directed_rows[8]  = pair_row(LABEL_POS, -16'sd1, 1'b0);
        directed_rows[9]  = pair_row(LABEL_NEG, -16'sd2048, 1'b0);
        directed_rows[10] = pair_row(LABEL_POS, 16'sd4096, 1'b0);
        directed_rows[11] = pair_row(LABEL_POS, 16'sh5555, 1'b0);
        directed_rows[12] = pair_row(LABEL_NEG, 16'shAAAA, 1'b1);
        // Lowest threshold: every score is positive.
        directed_rows[13] = cfg_row(16'sh8000);
        directed_rows[14] = checked_row(LABEL_NEG, 16'sh8000,
                                        make_report(0, 0, 1, 0, 0, 0, 0, 0, 0));
        directed_rows[15] = checked_row(LABEL_POS, 16'sh8000,
                                        make_report(0, 1, 0, 0, 0, 65536, 65536, 65536,
                                                    65536));
        // Highest threshold: only the largest score is positive.
        directed_rows[16] = cfg_row(16'sh7FFF);
        directed_rows[17] = pair_row(LABEL_POS, 16'sh7FFE, 1'b0);
        directed_rows[18] = checked_row(LABEL_POS, 16'sh7FFF,
                                        make_report(0, 1, 0, 0, 1, 32768, 65536, 32768,
                                                    43690));
        // Threshold at zero with ratios that do not divide evenly.
        directed_rows[19] = cfg_row(16'sd0);
        directed_rows[20] = pair_row(LABEL_NEG, 16'sd0, 1'b0);
        directed_rows[21] = pair_row(LABEL_NEG, -16'sd1, 1'b0);
        directed_rows[22] = pair_row(LABEL_POS, 16'sh4000, 1'b1);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].is_cfg)
                write_threshold(directed_rows[i].value);
            else
                send_pair(directed_rows[i].label, directed_rows[i].score,
                          directed_rows[i].last, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // Random phases. Each one writes a new threshold while the block is
        // idle, then streams batches of random length. Two phases run with
        // no gaps and no stalls at all.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1:       thr = 16'sh8000;
                2:       thr = 16'sh7FFF;
                3:       thr = 16'sd0;
                default: thr = score_t'($urandom);
            endcase
            steady = (phase == 1) || (phase == 4);
            write_threshold(thr);
            left = PHASE_PAIRS;
            while (left > 0)
            begin
                // Mostly short batches, now and then a long one.
                if ($urandom_range(0, 7) == 0)
                    blen = $urandom_range(60, 150);
                else
                    blen = $urandom_range(1, 30);
                if (blen > left)
                    blen = left;
                for (i = 0; i < blen; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 47)
                        l = LABEL_NEG;
                    else if (r < 94)
                        l = LABEL_POS;
                    else if (r < 97)
                        l = LABEL_INVALID_LO;
                    else
                        l = LABEL_INVALID_HI;
                    // Scores cluster around the threshold, at the extremes,
                    // or anywhere in range.
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            v = int'(model_threshold) + int'($urandom_range(0, 6)) - 3;
                            if (v > 32767)
                                v = 32767;
                            if (v < -32768)
                                v = -32768;
                            s = score_t'(v);
                        end
                        1:
                            s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        default:
                            s = score_t'($urandom);
                    endcase
                    send_pair(l, s, i == blen - 1, 1'b0, '0);
                end
                left -= blen;
                // Occasionally hold the source until the block has drained.
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (awaited_reports.size() != 0)
        begin
            $display("%0t: %0d batch reports never arrived", $time, awaited_reports.size());
            error_count++;
        end

        if (error_count == 0)
            $display("binary_classification_metrics regression: pass");
        else
            $display("binary_classification_metrics regression: fail");
        $finish;
    end

endmodule
